/* rtl/core/pntss_pkg.sv */
// types and constants shared by the pps / ntp time sync sequencer
`timescale 1ns / 1ps
`default_nettype none

package pntss_pkg;

    // sequencer phases, also the state code of a result
    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_DELAY     = 3'd1,
        PH_AWAIT_PPS = 3'd2,
        PH_AWAIT_NTP = 3'd3,
        PH_PAUSE     = 3'd4,
        PH_SYNCED    = 3'd5,
        PH_RESYNC    = 3'd6
    } t_phase;

    // configuration register indexes (byte address / 4)
    localparam logic [2:0] REG_ENABLED      = 3'd0;
    localparam logic [2:0] REG_STARTUP      = 3'd1;
    localparam logic [2:0] REG_FIRST_WAIT   = 3'd2;
    localparam logic [2:0] REG_NEXT_WAIT    = 3'd3;
    localparam logic [2:0] REG_NTP_TIMEOUT  = 3'd4;
    localparam logic [2:0] REG_POLL_EXP     = 3'd5;
    localparam logic [2:0] REG_REPORT       = 3'd6;

    // configuration reset values
    localparam logic        RST_ENABLED     = 1'b1;
    localparam logic [31:0] RST_STARTUP     = 32'd4000000;
    localparam logic [31:0] RST_FIRST_WAIT  = 32'd3100000;
    localparam logic [31:0] RST_NEXT_WAIT   = 32'd1000000;
    localparam logic [31:0] RST_NTP_TIMEOUT = 32'd800000;
    localparam logic [3:0]  RST_POLL_EXP    = 4'd3;
    localparam logic [7:0]  RST_REPORT      = 8'd60;

    // arithmetic constants
    localparam logic [31:0] EPOCH_OFFSET    = 32'd2208988800;
    localparam logic [31:0] QUARTER_FRAC    = 32'h4000_0000;
    localparam logic [31:0] US_PER_SEC      = 32'd1000000;
    localparam logic [31:0] MS_PER_SEC      = 32'd1000;
    localparam logic [3:0]  POLL_EXP_MAX    = 4'd12;

    typedef struct packed {
        logic        enabled;
        logic [31:0] startup_pause_us;
        logic [31:0] first_pps_wait_us;
        logic [31:0] next_pps_wait_us;
        logic [31:0] ntp_timeout_us;
        logic [3:0]  poll_exponent;
        logic [7:0]  report_period;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_us;
        logic        pps_valid;
        logic        pps_toggle;
        logic        seconds_valid;
        logic        reply_valid;
        logic        reply_long_enough;
        logic [31:0] reply_seconds;
        logic [31:0] reply_fraction;
        logic        resync_request;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic        last_toggle;
        logic        first_seen;
        logic [31:0] mark_time;
        logic        later_check;
        logic        missed_any;
        logic [7:0]  miss_count;
        logic [31:0] held_seconds;
        logic [31:0] held_fraction;
    } t_seq_state;

    typedef struct packed {
        logic [2:0]  state_code;
        logic        send_query;
        logic        seconds_write;
        logic [31:0] seconds_value;
        logic        late_marker;
        logic [9:0]  late_ms;
        logic        pps_missing_first;
        logic        pps_missing_report;
        logic        ntp_timeout;
        logic        pps_lost;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/pntss_step.sv */
// next-state and result logic for one sequencer transaction
`timescale 1ns / 1ps
`default_nettype none

module pntss_step (
    input  wire pntss_pkg::t_seq_state i_state,
    input  wire pntss_pkg::t_item      i_item,
    input  wire pntss_pkg::t_cfg       i_cfg,
    output pntss_pkg::t_seq_state      o_state,
    output pntss_pkg::t_result         o_result
);
    import pntss_pkg::*;

    logic        reply_take;
    logic [31:0] held_s;
    logic [31:0] held_f;
    t_phase      start_phase;
    logic        prev_toggle;
    logic [31:0] elapsed;
    logic [31:0] pps_limit;
    logic [3:0]  pause_exp;
    logic [31:0] pause_limit;
    logic [7:0]  miss_inc;
    logic [31:0] late_prod;

    // reply applied ahead of the crank
    assign reply_take  = i_item.reply_valid && i_item.reply_long_enough
                         && (i_state.held_seconds == '0);
    assign held_s      = reply_take ? (i_item.reply_seconds - EPOCH_OFFSET)
                                    : i_state.held_seconds;
    assign held_f      = reply_take ? i_item.reply_fraction : i_state.held_fraction;

    // resync request overrides the phase before the crank
    assign start_phase = i_item.resync_request ? PH_RESYNC : i_state.phase;

    // first sample never counts as an edge
    assign prev_toggle = i_state.first_seen ? i_state.last_toggle : i_item.pps_toggle;

    // wrapping elapsed time and timeout limits
    assign elapsed     = i_item.now_us - i_state.mark_time;
    assign pps_limit   = i_state.later_check ? i_cfg.next_pps_wait_us
                                             : i_cfg.first_pps_wait_us;
    assign pause_exp   = (i_cfg.poll_exponent > POLL_EXP_MAX) ? POLL_EXP_MAX
                                                              : i_cfg.poll_exponent;
    assign pause_limit = US_PER_SEC << pause_exp;
    assign miss_inc    = i_state.miss_count + 8'd1;

    // late marker in milliseconds: fraction scaled by 1000 / 2^32
    assign late_prod   = 32'(held_f[31:10]) * MS_PER_SEC;

    // sequencer crank
    always_comb begin
        o_state             = i_state;
        o_result            = '0;
        o_result.state_code = i_state.phase;
        if (i_cfg.enabled) begin
            o_state.held_seconds  = held_s;
            o_state.held_fraction = held_f;
            o_state.phase         = start_phase;
            o_state.first_seen    = 1'b1;
            o_state.last_toggle   = i_item.pps_toggle;
            unique case (start_phase)
                PH_START: begin
                    o_result.send_query  = 1'b1;
                    o_state.held_seconds = '0;
                    o_state.mark_time    = i_item.now_us;
                    o_state.phase        = PH_DELAY;
                end
                PH_DELAY: begin
                    if (elapsed > i_cfg.startup_pause_us) begin
                        o_state.mark_time = i_item.now_us;
                        o_state.phase     = PH_AWAIT_PPS;
                    end
                end
                PH_RESYNC: begin
                    o_state.missed_any = 1'b0;
                    o_state.miss_count = '0;
                    o_state.mark_time  = i_item.now_us;
                    o_state.phase      = PH_AWAIT_PPS;
                end
                PH_AWAIT_PPS: begin
                    if (i_item.pps_valid && (i_item.pps_toggle != prev_toggle)) begin
                        o_state.later_check  = 1'b1;
                        o_state.missed_any   = 1'b0;
                        o_state.miss_count   = '0;
                        o_result.send_query  = 1'b1;
                        o_state.held_seconds = '0;
                        o_state.mark_time    = i_item.now_us;
                        o_state.phase        = PH_AWAIT_NTP;
                    end else if (elapsed > pps_limit) begin
                        o_state.later_check         = 1'b1;
                        o_state.mark_time           = i_item.now_us;
                        o_result.pps_missing_first  = !i_state.missed_any;
                        o_state.missed_any          = 1'b1;
                        o_state.miss_count          = miss_inc;
                        // periodic still-missing report
                        if (miss_inc == i_cfg.report_period) begin
                            o_result.pps_missing_report = 1'b1;
                            o_state.miss_count          = '0;
                        end
                    end
                end
                PH_AWAIT_NTP: begin
                    if (held_s != '0) begin
                        o_result.seconds_write = 1'b1;
                        o_result.seconds_value = held_s;
                        if (held_f > QUARTER_FRAC) begin
                            o_result.late_marker = 1'b1;
                            o_result.late_ms     = late_prod[31:22];
                        end
                        o_state.phase = PH_SYNCED;
                    end else if (elapsed > i_cfg.ntp_timeout_us) begin
                        o_result.ntp_timeout = 1'b1;
                        o_state.phase        = PH_PAUSE;
                    end
                end
                PH_PAUSE: begin
                    if (elapsed > pause_limit) begin
                        o_state.mark_time = i_item.now_us;
                        o_state.phase     = PH_AWAIT_PPS;
                    end
                end
                PH_SYNCED: begin
                    if (!i_item.seconds_valid) begin
                        o_result.pps_lost = 1'b1;
                        o_state.phase     = PH_RESYNC;
                    end
                end
                default: begin
                    o_state.phase = PH_START;
                end
            endcase
            o_result.state_code = o_state.phase;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pps_ntp_time_sync_sequencer.sv */
// pps / ntp time sync sequencer: handshake, input and result registers, config port
// path: input register, then the step, then the result register and the outputs
// throughput: one transaction per cycle unless the result stalls, set by the single step
// between input and result registers; on a result stall one more enters the input register
// reset: synchronous active low, restores the register defaults and the start phase
`timescale 1ns / 1ps
`default_nettype none

module pps_ntp_time_sync_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_now_us,
    input  wire logic        i_pps_valid,
    input  wire logic        i_pps_toggle,
    input  wire logic        i_seconds_valid,
    input  wire logic        i_reply_valid,
    input  wire logic        i_reply_long_enough,
    input  wire logic [31:0] i_reply_seconds,
    input  wire logic [31:0] i_reply_fraction,
    input  wire logic        i_resync_request,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_state_code,
    output logic             o_send_query,
    output logic             o_seconds_write,
    output logic [31:0]      o_seconds_value,
    output logic             o_late_marker,
    output logic [9:0]       o_late_ms,
    output logic             o_pps_missing_first,
    output logic             o_pps_missing_report,
    output logic             o_ntp_timeout,
    output logic             o_pps_lost,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pntss_pkg::*;

    logic       r_in_valid;
    t_item      r_in;
    t_seq_state r_state;
    logic       r_out_valid;
    t_result    r_out;
    t_cfg       r_cfg;

    t_item      in_item;
    t_seq_state n_state;
    t_result    n_result;
    logic       fire;
    logic       in_take;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    // step fires when the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    assign in_item.now_us            = i_now_us;
    assign in_item.pps_valid         = i_pps_valid;
    assign in_item.pps_toggle        = i_pps_toggle;
    assign in_item.seconds_valid     = i_seconds_valid;
    assign in_item.reply_valid       = i_reply_valid;
    assign in_item.reply_long_enough = i_reply_long_enough;
    assign in_item.reply_seconds     = i_reply_seconds;
    assign in_item.reply_fraction    = i_reply_fraction;
    assign in_item.resync_request    = i_resync_request;

    pntss_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in <= in_item;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_START, default: '0};
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (fire) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_state_code         = r_out.state_code;
    assign o_send_query         = r_out.send_query;
    assign o_seconds_write      = r_out.seconds_write;
    assign o_seconds_value      = r_out.seconds_value;
    assign o_late_marker        = r_out.late_marker;
    assign o_late_ms            = r_out.late_ms;
    assign o_pps_missing_first  = r_out.pps_missing_first;
    assign o_pps_missing_report = r_out.pps_missing_report;
    assign o_ntp_timeout        = r_out.ntp_timeout;
    assign o_pps_lost           = r_out.pps_lost;

    // configuration writes
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled           <= RST_ENABLED;
            r_cfg.startup_pause_us  <= RST_STARTUP;
            r_cfg.first_pps_wait_us <= RST_FIRST_WAIT;
            r_cfg.next_pps_wait_us  <= RST_NEXT_WAIT;
            r_cfg.ntp_timeout_us    <= RST_NTP_TIMEOUT;
            r_cfg.poll_exponent     <= RST_POLL_EXP;
            r_cfg.report_period     <= RST_REPORT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ENABLED:     r_cfg.enabled           <= pwdata[0];
                REG_STARTUP:     r_cfg.startup_pause_us  <= pwdata;
                REG_FIRST_WAIT:  r_cfg.first_pps_wait_us <= pwdata;
                REG_NEXT_WAIT:   r_cfg.next_pps_wait_us  <= pwdata;
                REG_NTP_TIMEOUT: r_cfg.ntp_timeout_us    <= pwdata;
                REG_POLL_EXP:    r_cfg.poll_exponent     <= pwdata[3:0];
                REG_REPORT:      r_cfg.report_period     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_idx)
            REG_ENABLED:     prdata = 32'(r_cfg.enabled);
            REG_STARTUP:     prdata = r_cfg.startup_pause_us;
            REG_FIRST_WAIT:  prdata = r_cfg.first_pps_wait_us;
            REG_NEXT_WAIT:   prdata = r_cfg.next_pps_wait_us;
            REG_NTP_TIMEOUT: prdata = r_cfg.ntp_timeout_us;
            REG_POLL_EXP:    prdata = 32'(r_cfg.poll_exponent);
            REG_REPORT:      prdata = 32'(r_cfg.report_period);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/pntss_checker.sv */
// port-level checks for the pps / ntp time sync sequencer, with its bind
`timescale 1ns / 1ps
`default_nettype none

module pntss_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_state_code,
    input wire logic        o_send_query,
    input wire logic        o_seconds_write,
    input wire logic [31:0] o_seconds_value,
    input wire logic        o_late_marker,
    input wire logic [9:0]  o_late_ms,
    input wire logic        o_pps_lost
);
    import pntss_pkg::*;

    // a stalled result holds
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_state_code)
            && $stable(o_seconds_value))
        else $error("stalled result changed");

    // a query leaves the sequencer waiting for the delay or the reply
    a_query_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_query |->
            o_state_code == PH_DELAY || o_state_code == PH_AWAIT_NTP)
        else $error("query issued in wrong phase");

    // seconds load only on entry to synced, with a nonzero value
    a_write_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_seconds_write |->
            o_state_code == PH_SYNCED && o_seconds_value != '0)
        else $error("seconds write outside sync");

    // late milliseconds only with the late marker, and below one second
    a_late_ms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_late_marker || o_late_ms == '0) && o_late_ms <= 10'd999)
        else $error("late milliseconds out of range");

    // losing pps sends the sequencer to resync
    a_lost_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pps_lost |-> o_state_code == PH_RESYNC)
        else $error("pps lost without resync");

endmodule

bind pps_ntp_time_sync_sequencer pntss_checker u_pntss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_state_code    (o_state_code),
    .o_send_query    (o_send_query),
    .o_seconds_write (o_seconds_write),
    .o_seconds_value (o_seconds_value),
    .o_late_marker   (o_late_marker),
    .o_late_ms       (o_late_ms),
    .o_pps_lost      (o_pps_lost)
);

`default_nettype wire

/* tb/pntss_checker.sv */
// checker for the pps / ntp sync sequencer: watches both channels and the config port
`timescale 1ns / 1ps

module pntss_scoreboard (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input channel as seen at the block
    input  wire logic          i_in_valid,
    input  wire logic          i_in_stall,
    input  pntss_pkg::t_item   i_item,
    // result channel as seen at the block
    input  wire logic          i_out_valid,
    input  wire logic          i_out_stall,
    input  pntss_pkg::t_result i_result,
    // configuration port
    input  wire logic          i_psel,
    input  wire logic          i_penable,
    input  wire logic          i_pwrite,
    input  wire logic [4:0]    i_paddr,
    input  wire logic [31:0]   i_pwdata,
    input  wire logic          i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    import pntss_pkg::*;

    t_cfg       cfg_copy;
    t_seq_state seq;
    t_result    pending_results[$];
    int         fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one crank of the sequencer on our own copy of its state
    task automatic crank_sequencer(input t_item it, output t_result res);
        logic        prev_toggle;
        logic [31:0] elapsed;
        logic [31:0] pps_limit;
        logic [31:0] pause_limit;
        logic [31:0] ms_wide;
        logic [3:0]  exponent;
        res = '0;
        if (cfg_copy.enabled) begin
            // reply is latched first, only into an empty seconds holder
            if (it.reply_valid && it.reply_long_enough && seq.held_seconds == 32'd0) begin
                seq.held_seconds  = it.reply_seconds - EPOCH_OFFSET;
                seq.held_fraction = it.reply_fraction;
            end
            if (it.resync_request)
                seq.phase = PH_RESYNC;

            // no edge on the very first toggle sample
            prev_toggle    = seq.first_seen ? seq.last_toggle : it.pps_toggle;
            seq.first_seen = 1'b1;
            elapsed        = it.now_us - seq.mark_time;

            case (seq.phase)
                PH_START: begin
                    res.send_query   = 1'b1;
                    seq.held_seconds = 32'd0;
                    seq.mark_time    = it.now_us;
                    seq.phase        = PH_DELAY;
                end
                PH_DELAY: begin
                    if (elapsed > cfg_copy.startup_pause_us) begin
                        seq.mark_time = it.now_us;
                        seq.phase     = PH_AWAIT_PPS;
                    end
                end
                PH_RESYNC: begin
                    seq.missed_any = 1'b0;
                    seq.miss_count = 8'd0;
                    seq.mark_time  = it.now_us;
                    seq.phase      = PH_AWAIT_PPS;
                end
                PH_AWAIT_PPS: begin
                    pps_limit = seq.later_check ? cfg_copy.next_pps_wait_us
                                                : cfg_copy.first_pps_wait_us;
                    if (it.pps_valid && it.pps_toggle != prev_toggle) begin
                        seq.later_check  = 1'b1;
                        seq.missed_any   = 1'b0;
                        seq.miss_count   = 8'd0;
                        res.send_query   = 1'b1;
                        seq.held_seconds = 32'd0;
                        seq.mark_time    = it.now_us;
                        seq.phase        = PH_AWAIT_NTP;
                    end else if (elapsed > pps_limit) begin
                        // missed edge: first warning, then a report every period
                        seq.later_check = 1'b1;
                        seq.mark_time   = it.now_us;
                        if (!seq.missed_any)
                            res.pps_missing_first = 1'b1;
                        seq.missed_any = 1'b1;
                        seq.miss_count = seq.miss_count + 8'd1;
                        if (seq.miss_count == cfg_copy.report_period) begin
                            res.pps_missing_report = 1'b1;
                            seq.miss_count         = 8'd0;
                        end
                    end
                end
                PH_AWAIT_NTP: begin
                    if (seq.held_seconds != 32'd0) begin
                        res.seconds_write = 1'b1;
                        res.seconds_value = seq.held_seconds;
                        if (seq.held_fraction > QUARTER_FRAC) begin
                            res.late_marker = 1'b1;
                            ms_wide         = ((seq.held_fraction >> 10) * MS_PER_SEC) >> 22;
                            res.late_ms     = ms_wide[9:0];
                        end
                        seq.phase = PH_SYNCED;
                    end else if (elapsed > cfg_copy.ntp_timeout_us) begin
                        res.ntp_timeout = 1'b1;
                        seq.phase       = PH_PAUSE;
                    end
                end
                PH_PAUSE: begin
                    exponent    = (cfg_copy.poll_exponent > POLL_EXP_MAX) ? POLL_EXP_MAX
                                                                         : cfg_copy.poll_exponent;
                    pause_limit = (32'd1 << exponent) * US_PER_SEC;
                    if (elapsed > pause_limit) begin
                        seq.mark_time = it.now_us;
                        seq.phase     = PH_AWAIT_PPS;
                    end
                end
                PH_SYNCED: begin
                    if (!it.seconds_valid) begin
                        res.pps_lost = 1'b1;
                        seq.phase    = PH_RESYNC;
                    end
                end
                default: begin
                    seq.phase = PH_START;
                end
            endcase
            seq.last_toggle = it.pps_toggle;
        end
        res.state_code = seq.phase;
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // per-edge bookkeeping: results out, register writes, transactions in
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            cfg_copy = '{RST_ENABLED, RST_STARTUP, RST_FIRST_WAIT, RST_NEXT_WAIT,
                         RST_NTP_TIMEOUT, RST_POLL_EXP, RST_REPORT};
            seq       = '0;
            seq.phase = PH_START;
            pending_results.delete();
        end else begin
            // result transaction against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got = i_result;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected, actual state_code %0d",
                             $time, got.state_code);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("state_code", 32'(want.state_code), 32'(got.state_code));
                    compare_field("send_query", 32'(want.send_query), 32'(got.send_query));
                    compare_field("seconds_write", 32'(want.seconds_write),
                                  32'(got.seconds_write));
                    compare_field("seconds_value", want.seconds_value, got.seconds_value);
                    compare_field("late_marker", 32'(want.late_marker), 32'(got.late_marker));
                    compare_field("late_ms", 32'(want.late_ms), 32'(got.late_ms));
                    compare_field("pps_missing_first", 32'(want.pps_missing_first),
                                  32'(got.pps_missing_first));
                    compare_field("pps_missing_report", 32'(want.pps_missing_report),
                                  32'(got.pps_missing_report));
                    compare_field("ntp_timeout", 32'(want.ntp_timeout), 32'(got.ntp_timeout));
                    compare_field("pps_lost", 32'(want.pps_lost), 32'(got.pps_lost));
                end
            end

            // register write on the access cycle
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_ENABLED:     cfg_copy.enabled           = i_pwdata[0];
                    REG_STARTUP:     cfg_copy.startup_pause_us  = i_pwdata;
                    REG_FIRST_WAIT:  cfg_copy.first_pps_wait_us = i_pwdata;
                    REG_NEXT_WAIT:   cfg_copy.next_pps_wait_us  = i_pwdata;
                    REG_NTP_TIMEOUT: cfg_copy.ntp_timeout_us    = i_pwdata;
                    REG_POLL_EXP:    cfg_copy.poll_exponent     = i_pwdata[3:0];
                    REG_REPORT:      cfg_copy.report_period     = i_pwdata[7:0];
                    default: ;
                endcase
            end

            // input transaction
            if (i_in_valid && !i_in_stall) begin
                crank_sequencer(i_item, want);
                pending_results.push_back(want);
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_count;
    end

endmodule

/* tb/tb.sv */
// testbench top for the pps / ntp sync sequencer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import pntss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_item       in_item    = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_state_code;
    logic        o_send_query;
    logic        o_seconds_write;
    logic [31:0] o_seconds_value;
    logic        o_late_marker;
    logic [9:0]  o_late_ms;
    logic        o_pps_missing_first;
    logic        o_pps_missing_report;
    logic        o_ntp_timeout;
    logic        o_pps_lost;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    t_result     dut_result;
    int          fail_count;
    int          pending;
    int          cycle_count;

    // virtual microsecond clock and pps toggle seen by the stimulus
    logic [31:0] vnow = '0;
    logic        vtog = 1'b0;
    int          burst_left = 0;

    assign dut_result = {o_state_code, o_send_query, o_seconds_write, o_seconds_value,
                         o_late_marker, o_late_ms, o_pps_missing_first,
                         o_pps_missing_report, o_ntp_timeout, o_pps_lost};

    pps_ntp_time_sync_sequencer DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_now_us             (in_item.now_us),
        .i_pps_valid          (in_item.pps_valid),
        .i_pps_toggle         (in_item.pps_toggle),
        .i_seconds_valid      (in_item.seconds_valid),
        .i_reply_valid        (in_item.reply_valid),
        .i_reply_long_enough  (in_item.reply_long_enough),
        .i_reply_seconds      (in_item.reply_seconds),
        .i_reply_fraction     (in_item.reply_fraction),
        .i_resync_request     (in_item.resync_request),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_state_code         (o_state_code),
        .o_send_query         (o_send_query),
        .o_seconds_write      (o_seconds_write),
        .o_seconds_value      (o_seconds_value),
        .o_late_marker        (o_late_marker),
        .o_late_ms            (o_late_ms),
        .o_pps_missing_first  (o_pps_missing_first),
        .o_pps_missing_report (o_pps_missing_report),
        .o_ntp_timeout        (o_ntp_timeout),
        .o_pps_lost           (o_pps_lost),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    pntss_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_item       (in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_result     (dut_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pps_ntp_time_sync_sequencer regression: fail");
        $finish;
    end

    // result side stalls: random segments, plus one long hold-off to fill the block
    initial begin
        int seg_len;
        int mode;
        int pct;
        int cycles_run;
        bit held_off;
        cycles_run = 0;
        held_off   = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held_off && cycles_run >= 300) begin
                held_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                cycles_run += 200;
            end
            seg_len = $urandom_range(20, 150);
            mode    = $urandom_range(0, 3);
            pct     = $urandom_range(10, 75);
            repeat (seg_len) begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 99) < pct);
                    2: i_out_stall <= ~i_out_stall;
                    default: i_out_stall <= ($urandom_range(0, 99) < 20);
                endcase
                @(posedge i_clk);
                cycles_run++;
            end
        end
    end

    // register write: setup cycle, access cycle, then an idle cycle
    task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one transaction, in bursts with random gaps between them
    task automatic offer(input t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_item    <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic directed(input logic [31:0] step, input logic ppsv, input logic tog,
                            input logic secv, input logic rv, input logic rl,
                            input logic [31:0] rs, input logic [31:0] rf, input logic rsync);
        vnow += step;
        vtog = tog;
        offer(t_item'{vnow, ppsv, tog, secv, rv, rl, rs, rf, rsync});
    endtask

    // random crank: mostly small time steps, now and then long jumps and wraps
    task automatic make_item(input bit storm, output t_item it);
        int          pick;
        logic [31:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            step = 32'd0;
        else if (pick < 82)
            step = $urandom_range(1, 64);
        else if (pick < 92)
            step = $urandom_range(0, 2 ** 21);
        else if (pick < 98)
            step = $urandom_range(0, 2 ** 24);
        else
            step = $urandom;
        vnow += step;
        it = '0;
        it.now_us = vnow;
        it.reply_seconds  = $urandom;
        it.reply_fraction = $urandom;
        if (storm) begin
            // no pps edges and no replies: misses pile up
            it.pps_valid     = 1'($urandom_range(0, 1));
            it.pps_toggle    = vtog;
            it.seconds_valid = 1'($urandom_range(0, 1));
        end else begin
            if ($urandom_range(0, 99) < 15)
                vtog = ~vtog;
            it.pps_toggle        = vtog;
            it.pps_valid         = ($urandom_range(0, 99) < 85);
            it.seconds_valid     = ($urandom_range(0, 99) >= 5);
            it.reply_valid       = ($urandom_range(0, 99) < 25);
            it.reply_long_enough = ($urandom_range(0, 99) < 85);
            it.resync_request    = ($urandom_range(0, 99) < 2);
            case ($urandom_range(0, 9))
                0: it.reply_seconds = EPOCH_OFFSET;
                1: it.reply_seconds = 32'd0;
                2: it.reply_seconds = 32'hFFFF_FFFF;
                3: it.reply_seconds = EPOCH_OFFSET + 32'd1;
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0: it.reply_fraction = QUARTER_FRAC;
                1: it.reply_fraction = QUARTER_FRAC + 32'd1;
                2: it.reply_fraction = 32'hFFFF_FFFF;
                3: it.reply_fraction = 32'd0;
                default: ;
            endcase
        end
    endtask

    // one configuration setting and its share of random transactions
    task automatic run_regime(input t_cfg c, input int n_items, input bit storm);
        t_item it;
        apb_write(REG_ENABLED, {31'd0, c.enabled});
        apb_write(REG_STARTUP, c.startup_pause_us);
        apb_write(REG_FIRST_WAIT, c.first_pps_wait_us);
        apb_write(REG_NEXT_WAIT, c.next_pps_wait_us);
        apb_write(REG_NTP_TIMEOUT, c.ntp_timeout_us);
        apb_write(REG_POLL_EXP, {28'd0, c.poll_exponent});
        apb_write(REG_REPORT, {24'd0, c.report_period});
        for (int k = 0; k < n_items; k++) begin
            make_item(storm, it);
            offer(it);
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk through every phase with the reset settings
        directed(32'd100, 1, 1, 1, 1, 1, 32'hDEAD_BEEF, 32'h1234_5678, 0);   // query
        directed(32'd4000000, 1, 1, 1, 0, 0, 32'd0, 32'd0, 0);   // pause exactly met
        directed(32'd1, 1, 1, 1, 0, 0, 32'd0, 32'd0, 0);         // on to pps search
        directed(32'd10, 1, 1, 1, 0, 0, 32'd0, 32'd0, 0);        // toggle unchanged
        directed(32'd10, 0, 0, 1, 0, 0, 32'd0, 32'd0, 0);        // toggle with pps invalid
        directed(32'd10, 1, 1, 1, 0, 0, 32'd0, 32'd0, 0);        // edge, query
        directed(32'd10, 1, 1, 1, 1, 0, EPOCH_OFFSET + 32'd5, 32'd0, 0);     // short reply
        directed(32'd10, 1, 1, 1, 1, 1, EPOCH_OFFSET, 32'd0, 0);  // converts to zero
        directed(32'd10, 1, 1, 1, 1, 1, EPOCH_OFFSET + 32'd1000, 32'hFFFF_FFFF, 0);
        directed(32'd10, 1, 1, 1, 1, 1, 32'hCAFE_0001, 32'h8000_0000, 0);    // held, ignored
        directed(32'd10, 1, 1, 0, 0, 0, 32'd0, 32'd0, 0);        // seconds lost
        directed(32'd10, 1, 1, 1, 0, 0, 32'd0, 32'd0, 0);        // resync
        directed(32'd1000001, 1, 1, 1, 0, 0, 32'd0, 32'd0, 0);   // first miss
        directed(32'd1000001, 1, 1, 1, 0, 0, 32'd0, 32'd0, 0);   // further miss
        directed(32'd10, 1, 1, 1, 0, 0, 32'd0, 32'd0, 1);        // resync request
        directed(32'd10, 1, 0, 1, 0, 0, 32'd0, 32'd0, 0);        // edge, query
        directed(32'd800001, 1, 0, 1, 0, 0, 32'd0, 32'd0, 0);    // ntp timeout
        directed(32'd8000000, 1, 0, 1, 0, 0, 32'd0, 32'd0, 0);   // pause over, counted from the edge
        directed(32'd1, 1, 0, 1, 0, 0, 32'd0, 32'd0, 0);         // pps search, toggle unchanged
        directed(32'd10, 1, 1, 1, 0, 0, 32'd0, 32'd0, 0);        // edge, query
        directed(32'd10, 1, 1, 1, 1, 1, EPOCH_OFFSET + 32'd77, QUARTER_FRAC, 0);
        directed(32'd10, 1, 1, 0, 0, 0, 32'd0, 32'd0, 0);        // seconds lost
        directed(32'd10, 1, 1, 1, 0, 0, 32'd0, 32'd0, 0);        // resync
        directed(32'd10, 1, 0, 1, 0, 0, 32'd0, 32'd0, 0);        // edge, query
        directed(32'd10, 1, 0, 1, 1, 1, 32'd0, QUARTER_FRAC + 32'd1, 0);    // epoch wraps
        drain();

        // short timeouts, frequent reports
        run_regime(t_cfg'{1'b1, 32'd20, 32'd100, 32'd60, 32'd50, 4'd0, 8'd3}, 200, 1'b0);
        // zero timeouts
        run_regime(t_cfg'{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0, 8'd1}, 120, 1'b0);
        // report period of zero: a report on every wrap of the miss count
        run_regime(t_cfg'{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0, 8'd0}, 300, 1'b1);
        // build up misses, then lower the period below the count
        run_regime(t_cfg'{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0, 8'd255}, 100, 1'b1);
        run_regime(t_cfg'{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0, 8'd2}, 200, 1'b1);
        // disabled
        run_regime(t_cfg'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 4'd15, 8'd255}, 40, 1'b0);
        // longest timeouts, exponent beyond its range
        run_regime(t_cfg'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 4'd15, 8'd255}, 60, 1'b0);
        run_regime(t_cfg'{1'b1, 32'd30, 32'h8000_0000, 32'd200, 32'hFFFF_FFFF,
                          4'd13, 8'd4}, 60, 1'b0);
        run_regime(t_cfg'{1'b1, 32'd40, 32'd500, 32'd300, 32'd100, 4'd12, 8'd1}, 60, 1'b0);
        // reset values again
        run_regime(t_cfg'{RST_ENABLED, RST_STARTUP, RST_FIRST_WAIT, RST_NEXT_WAIT,
                          RST_NTP_TIMEOUT, RST_POLL_EXP, RST_REPORT}, 100, 1'b0);
        run_regime(t_cfg'{1'b1, 32'd15, 32'd40, 32'd25, 32'd35, 4'd1, 8'd5}, 130, 1'b0);

        if (fail_count == 0)
            $display("pps_ntp_time_sync_sequencer regression: pass");
        else
            $display("pps_ntp_time_sync_sequencer regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pntss_pkg.sv
rtl/core/pntss_step.sv
rtl/core/pps_ntp_time_sync_sequencer.sv
rtl/core/pntss_checker.sv
tb/pntss_checker.sv
tb/tb.sv
